// ===== sv/tsw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared types and constants for the texture sampler.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int MAX_SIDE = 256;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_CLAMP  = 2'd1;
    localparam logic [1:0] WRAP_MIRROR = 2'd2;
    localparam logic [1:0] WRAP_RSVD   = 2'd3;

    localparam logic FILTER_NEAREST  = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER = 2'd2;
    localparam logic [1:0] REG_WRAP   = 2'd3;

    localparam logic [31:0] BLACK = 32'hFF00_0000;

    typedef struct packed {
        logic [8:0] width;
        logic [8:0] height;
        logic       filter;
        logic [1:0] wrap;
    } cfg_t;

endpackage

// ===== sv/tsw_bank.sv =====
// ----------------------------------------------------------------------------
// tsw_bank
// One texel bank: single write port, single registered read port.
// ----------------------------------------------------------------------------
module tsw_bank #(
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/texture_sampler_wrap_bilinear_unit.sv =====
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear_unit
// Texel store with wrap modes and nearest or bilinear filtering.
// ----------------------------------------------------------------------------
// One request per cycle while the output is not stalled; a result passes
// through the wrap, scale, bank read, weight and output register stages,
// and a stalled output holds the whole pipeline. Writes and unknown commands
// give no result. The store is four banks split by x and y parity, so the
// four bilinear neighbours are read in the same cycle; writes go to one bank. A
// write lands in its bank as it leaves the scale stage, before any later
// request reads there, so no bypass is needed. tdata of the input: command,
// coord_u, coord_v, texel_x, texel_y, red, green, blue, alpha from bit 0 up.
// Output: red, green, blue, alpha.
module texture_sampler_wrap_bilinear_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [8:0]    cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // command[1:0], coord_u[33:2], coord_v[65:34], texel_x[73:66],
    // texel_y[81:74], red[89:82], green[97:90], blue[105:98], alpha[113:106]
    input  logic [119:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [31:0]   m_axis_tdata
);

    localparam int SB = $clog2(tsw_pkg::MAX_SIDE);
    localparam int HB = (SB > 1) ? SB - 1 : 1;
    localparam int AW = 2 * HB;
    localparam logic [8:0] MAXS = 9'(tsw_pkg::MAX_SIDE);

    tsw_pkg::cfg_t cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{width: 9'd0, height: 9'd0, filter: tsw_pkg::FILTER_BILINEAR,
                         wrap: tsw_pkg::WRAP_REPEAT};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tsw_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_data;
                tsw_pkg::REG_HEIGHT: cfg_reg.height <= cfg_data;
                tsw_pkg::REG_FILTER: cfg_reg.filter <= cfg_data[0];
                tsw_pkg::REG_WRAP:   cfg_reg.wrap   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    logic [8:0] w_eff, h_eff;
    assign w_eff = (cfg_reg.width > MAXS) ? MAXS : cfg_reg.width;
    assign h_eff = (cfg_reg.height > MAXS) ? MAXS : cfg_reg.height;

    // pipeline control
    logic [3:0] vld_reg;
    logic       adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    function automatic logic [16:0] wrap_c(input logic [31:0] c, input logic [1:0] m);
        logic [16:0] r;
        if (m == tsw_pkg::WRAP_CLAMP)
        begin
            if (c[31]) r = 17'd0;
            else if (c > 32'd65536) r = 17'h10000;
            else r = c[16:0];
        end
        else if (m == tsw_pkg::WRAP_MIRROR && c[16])
            r = 17'h10000 - {1'b0, c[15:0]};
        else
            r = {1'b0, c[15:0]};
        return r;
    endfunction

    // stage 1: wrap
    logic [1:0]  s1_cmd_reg;
    logic [16:0] s1_tu_reg, s1_tv_reg;
    logic [7:0]  s1_x_reg, s1_y_reg;
    logic [31:0] s1_col_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= s_axis_tdata[1:0];
            s1_tu_reg  <= wrap_c(s_axis_tdata[33:2], cfg_reg.wrap);
            s1_tv_reg  <= wrap_c(s_axis_tdata[65:34], cfg_reg.wrap);
            s1_x_reg   <= s_axis_tdata[73:66];
            s1_y_reg   <= s_axis_tdata[81:74];
            s1_col_reg <= s_axis_tdata[113:82];
        end
    end

    // stage 2: scale, form neighbour coordinates (signed, 11 bits)
    logic [25:0] qx, qy;
    assign qx = 26'(s1_tu_reg) * 26'(w_eff) + (cfg_reg.filter ? 26'd32768 : 26'd0);
    assign qy = 26'(s1_tv_reg) * 26'(h_eff) + (cfg_reg.filter ? 26'd32768 : 26'd0);

    logic [1:0]  s2_cmd_reg;
    logic        s2_bil_reg;
    logic signed [10:0] s2_x0_reg, s2_y0_reg;
    logic [7:0]  s2_fx_reg, s2_fy_reg;
    logic [31:0] s2_col_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_col_reg <= s1_col_reg;
            s2_bil_reg <= (s1_cmd_reg == tsw_pkg::CMD_SAMPLE) && cfg_reg.filter;
            if (s1_cmd_reg == tsw_pkg::CMD_SAMPLE)
            begin
                if (cfg_reg.filter)
                begin
                    s2_x0_reg <= $signed({1'b0, qx[25:16]}) - 11'sd1;
                    s2_y0_reg <= $signed({1'b0, qy[25:16]}) - 11'sd1;
                end
                else
                begin
                    s2_x0_reg <= $signed({1'b0, qx[25:16]});
                    s2_y0_reg <= $signed({1'b0, qy[25:16]});
                end
            end
            else
            begin
                s2_x0_reg <= $signed({3'b0, s1_x_reg});
                s2_y0_reg <= $signed({3'b0, s1_y_reg});
            end
            s2_fx_reg <= cfg_reg.filter ? qx[15:8] : 8'd0;
            s2_fy_reg <= cfg_reg.filter ? qy[15:8] : 8'd0;
        end
    end

    // neighbour (dx,dy): coordinates, inside test, bank selection
    logic signed [10:0] nx [4];
    logic signed [10:0] ny [4];
    logic [3:0]  n_in;
    logic [HB-1:0] bank_col [4];
    logic [HB-1:0] bank_row [4];
    logic [1:0]  n_bank [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            nx[k] = s2_x0_reg + 11'(k & 1);
            ny[k] = s2_y0_reg + 11'(k >> 1);
            n_in[k] = !nx[k][10] && !ny[k][10]
                      && (nx[k] < $signed({2'b0, w_eff}))
                      && (ny[k] < $signed({2'b0, h_eff}));
            n_bank[k] = {ny[k][0], nx[k][0]};
        end
        // each bank takes the neighbour whose parity matches
        for (int b = 0; b < 4; b++)
        begin
            bank_col[b] = '0;
            bank_row[b] = '0;
            for (int k = 0; k < 4; k++)
            begin
                if (n_bank[k] == 2'(b))
                begin
                    bank_col[b] = nx[k][HB:1];
                    bank_row[b] = ny[k][HB:1];
                end
            end
        end
    end

    // write path from stage 2
    logic do_wr;
    assign do_wr = adv && vld_reg[1] && s2_cmd_reg == tsw_pkg::CMD_WRITE && n_in[0];

    logic [31:0] bank_q [4];
    genvar gb;
    generate
        for (gb = 0; gb < 4; gb++)
        begin : g_bank
            tsw_bank #(.AW(AW)) u_bank (
                .clk   (clk),
                .we    (do_wr && n_bank[0] == 2'(gb)),
                .waddr ({s2_y0_reg[HB:1], s2_x0_reg[HB:1]}),
                .wdata (s2_col_reg),
                .raddr ({bank_row[gb], bank_col[gb]}),
                .rdata (bank_q[gb])
            );
        end
    endgenerate

    // stage 3: memory read out
    logic [1:0]  s3_cmd_reg;
    logic        s3_bil_reg;
    logic [3:0]  s3_in_reg;
    logic [1:0]  s3_bank_reg [4];
    logic [7:0]  s3_fx_reg, s3_fy_reg;
    logic        s3_hold_reg;
    logic [31:0] hq_reg [4];
    always_ff @(posedge clk)
    begin
        s3_hold_reg <= !adv;
        if (adv)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            s3_bil_reg <= s2_bil_reg;
            s3_in_reg  <= n_in;
            s3_fx_reg  <= s2_fx_reg;
            s3_fy_reg  <= s2_fy_reg;
            for (int k = 0; k < 4; k++)
            begin
                s3_bank_reg[k] <= n_bank[k];
            end
        end
        if (!s3_hold_reg)
        begin
            for (int b = 0; b < 4; b++)
            begin
                hq_reg[b] <= bank_q[b];
            end
        end
    end

    logic [31:0] bq [4];
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            bq[b] = s3_hold_reg ? hq_reg[b] : bank_q[b];
        end
    end

    logic [31:0] tex [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            tex[k] = s3_in_reg[k] ? bq[s3_bank_reg[k]] : tsw_pkg::BLACK;
        end
    end

    // stage 4: weight products
    logic [8:0] wx0, wy0;
    assign wx0 = 9'd256 - {1'b0, s3_fx_reg};
    assign wy0 = 9'd256 - {1'b0, s3_fy_reg};
    logic [17:0] wt [4];
    assign wt[0] = 18'(wx0) * 18'(wy0);
    assign wt[1] = 18'(s3_fx_reg) * 18'(wy0);
    assign wt[2] = 18'(wx0) * 18'(s3_fy_reg);
    assign wt[3] = 18'(s3_fx_reg) * 18'(s3_fy_reg);

    logic [1:0]  s4_cmd_reg;
    logic        s4_bil_reg;
    logic [31:0] s4_tex_reg [4];
    logic [17:0] s4_wt_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_cmd_reg <= s3_cmd_reg;
            s4_bil_reg <= s3_bil_reg;
            for (int k = 0; k < 4; k++)
            begin
                s4_tex_reg[k] <= tex[k];
                s4_wt_reg[k]  <= wt[k];
            end
        end
    end

    logic [31:0] blend;
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            logic [27:0] acc;
            acc = '0;
            for (int k = 0; k < 4; k++)
            begin
                acc = acc + 28'(s4_tex_reg[k][8*c +: 8]) * 28'(s4_wt_reg[k]);
            end
            blend[8*c +: 8] = acc[23:16];
        end
    end

    logic [31:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= s4_bil_reg ? blend : s4_tex_reg[0];
        end
    end
    assign m_axis_tdata = out_reg;

    // valid chain: bit i marks stage i+1 holds a request
    logic s4_res;
    assign s4_res = s4_cmd_reg == tsw_pkg::CMD_READ || s4_cmd_reg == tsw_pkg::CMD_SAMPLE;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], in_fire};
            m_axis_tvalid <= vld_reg[3] && s4_res;
        end
    end

    logic unused;
    assign unused = ^s_axis_tdata[119:114];

endmodule
